FILE: rtl/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg
// shared widths, issuer class codes and digit arithmetic helpers for the
// card number check pipeline
// ----------------------------------------------------------------------------
package cnlc_pkg;

  // card number width and its padded stream width
  localparam int CARD_W     = 54;
  localparam int IN_DATA_W  = ((CARD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  // decimal digits needed to hold any CARD_W-bit value
  localparam int NDIG   = 17;
  localparam int BCD_W  = NDIG * 4;
  localparam int NPAIR  = (NDIG + 1) / 2;

  // binary to bcd conversion: bits shifted in per pipeline stage
  localparam int STEP   = 6;
  localparam int NCONV  = CARD_W / STEP;

  // digit limit for a classified number
  localparam int MAX_DIGITS = 16;

  // issuer class codes
  localparam logic [1:0] CLS_INVALID = 2'd0;
  localparam logic [1:0] CLS_15_3X   = 2'd1;
  localparam logic [1:0] CLS_16_5X   = 2'd2;
  localparam logic [1:0] CLS_LEAD_4  = 2'd3;

  // luhn contribution of one digit, doubled or plain
  function automatic logic [3:0] luhn_val(input logic [3:0] d, input logic dbl);
    logic [4:0] two;
    two = {d, 1'b0};
    if (!dbl) begin
      luhn_val = d;
    end else if (two > 5'd9) begin
      luhn_val = 4'(two - 5'd9);
    end else begin
      luhn_val = two[3:0];
    end
  endfunction

  // remainder by ten of an 8-bit sum, reciprocal multiply (exact below 1029)
  function automatic logic [3:0] mod10(input logic [7:0] x);
    logic [18:0] prod;
    logic [7:0]  q;
    logic [11:0] qx10;
    prod = 19'(x) * 19'd205;
    q    = prod[18:11];
    qx10 = 12'(q) * 12'd10;
    mod10 = 4'(12'(x) - qx10);
  endfunction

endpackage

FILE: rtl/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// luhn mod-10 check, digit count and issuer class of a binary card number
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one request per card number, in_tdata[53:0] holds the number
//           as an unsigned binary integer, upper pad bits are ignored
//   out_* : one result per request, in the same order
//           out_tdata[1:0] issuer class, [2] checksum ok, [7:3] digit count
// stages : 12 register stages from an accepted request to out_tvalid,
//           the first loaded at the accepting edge: 9 conversion stages
//           of 6 bits each, then luhn digit values, sum and class, and
//           the output register
// throughput : one request per cycle while no result is held at the output,
//           set by the 9-stage binary to bcd pipeline, 6 bits per stage
// stall : the whole pipeline advances together; when the output register
//           holds a result that is not taken, in_tready drops and every
//           stage holds, so nothing is lost or repeated
// reset : synchronous rst_n clears all stage valid bits; the pipeline
//           comes up empty and ready
// ----------------------------------------------------------------------------
module card_number_luhn_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [53:0] card_number, [55:54] zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cnlc_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [1:0] issuer_class, [2] checksum_ok, [7:3] digit_count
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cnlc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // global advance: move when the output slot is free or being taken
  logic advance;
  logic out_valid_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // ---------------------------------------------------------------------
  // binary to bcd conversion chain
  // ---------------------------------------------------------------------
  logic                        cv_valid [cnlc_pkg::NCONV+1];
  logic [cnlc_pkg::BCD_W-1:0]  cv_bcd   [cnlc_pkg::NCONV+1];
  logic [cnlc_pkg::CARD_W-1:0] cv_bin   [cnlc_pkg::NCONV+1];

  assign cv_valid[0] = in_tvalid;
  assign cv_bcd[0]   = '0;
  assign cv_bin[0]   = in_tdata[cnlc_pkg::CARD_W-1:0];

  for (genvar g = 0; g < cnlc_pkg::NCONV; g++) begin : g_conv
    cnlc_dabble_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (advance),
      .in_valid    (cv_valid[g]),
      .in_bcd      (cv_bcd[g]),
      .in_bin      (cv_bin[g]),
      .out_valid_r (cv_valid[g+1]),
      .out_bcd_r   (cv_bcd[g+1]),
      .out_bin_r   (cv_bin[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // stage a: luhn digit values paired up, digit count, leading digits
  // ---------------------------------------------------------------------
  logic [3:0] dig [cnlc_pkg::NDIG];

  for (genvar g = 0; g < cnlc_pkg::NDIG; g++) begin : g_dig
    assign dig[g] = cv_bcd[cnlc_pkg::NCONV][4*g +: 4];
  end

  logic       a_valid_r;
  logic [4:0] a_psum_nxt [cnlc_pkg::NPAIR];
  logic [4:0] a_psum_r   [cnlc_pkg::NPAIR];
  logic [4:0] a_cnt_nxt, a_cnt_r;
  logic [3:0] a_d15_r, a_d14_r, a_d13_r, a_d12_r;

  // digit 2j is plain, digit 2j+1 is doubled (odd positions from the right)
  // the top digit has no partner and is never doubled
  always_comb begin
    for (int j = 0; j < cnlc_pkg::NDIG / 2; j++) begin
      a_psum_nxt[j] = 5'(cnlc_pkg::luhn_val(dig[2*j], 1'b0)) +
                      5'(cnlc_pkg::luhn_val(dig[2*j+1], 1'b1));
    end
    a_psum_nxt[cnlc_pkg::NPAIR-1] = 5'(dig[cnlc_pkg::NDIG-1]);
  end

  // count is one past the highest nonzero digit
  always_comb begin
    a_cnt_nxt = '0;
    for (int i = 0; i < cnlc_pkg::NDIG; i++) begin
      if (dig[i] != 4'd0) begin
        a_cnt_nxt = 5'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= cv_valid[cnlc_pkg::NCONV];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_psum_r <= a_psum_nxt;
      a_cnt_r  <= a_cnt_nxt;
      a_d15_r  <= dig[15];
      a_d14_r  <= dig[14];
      a_d13_r  <= dig[13];
      a_d12_r  <= dig[12];
    end
  end

  // ---------------------------------------------------------------------
  // stage b: luhn sum and tentative issuer class
  // ---------------------------------------------------------------------
  logic       b_valid_r;
  logic [7:0] b_sum_nxt, b_sum_r;
  logic [1:0] b_cls_nxt, b_cls_r;
  logic [4:0] b_cnt_r;
  logic       is_15_3x, is_16_5x, is_lead_4, within_limit;

  always_comb begin
    b_sum_nxt = '0;
    for (int j = 0; j < cnlc_pkg::NPAIR; j++) begin
      b_sum_nxt = b_sum_nxt + 8'(a_psum_r[j]);
    end
  end

  // leading digits sit at fixed places for the three counts of interest
  assign is_15_3x  = (a_cnt_r == 5'd15) && (a_d14_r == 4'd3) &&
                     ((a_d13_r == 4'd4) || (a_d13_r == 4'd7));
  assign is_16_5x  = (a_cnt_r == 5'd16) && (a_d15_r == 4'd5) &&
                     (a_d14_r >= 4'd1) && (a_d14_r <= 4'd5);
  assign is_lead_4 = ((a_cnt_r == 5'd13) && (a_d12_r == 4'd4)) ||
                     ((a_cnt_r == 5'd16) && (a_d15_r == 4'd4));
  assign within_limit = (a_cnt_r <= 5'(cnlc_pkg::MAX_DIGITS));

  // over the digit limit is invalid, else classes tried in order: fifteen-digit, sixteen-digit, leading four
  always_comb begin
    if (!within_limit) begin
      b_cls_nxt = cnlc_pkg::CLS_INVALID;
    end else if (is_15_3x) begin
      b_cls_nxt = cnlc_pkg::CLS_15_3X;
    end else if (is_16_5x) begin
      b_cls_nxt = cnlc_pkg::CLS_16_5X;
    end else if (is_lead_4) begin
      b_cls_nxt = cnlc_pkg::CLS_LEAD_4;
    end else begin
      b_cls_nxt = cnlc_pkg::CLS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_sum_r <= b_sum_nxt;
      b_cls_r <= b_cls_nxt;
      b_cnt_r <= a_cnt_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: mod-10 test, final class, output register
  // ---------------------------------------------------------------------
  logic       pass;
  logic [1:0] out_cls_r;
  logic       out_ok_r;
  logic [4:0] out_cnt_r;

  // a zero number has no digits and never passes
  assign pass = (b_cnt_r != 5'd0) && (cnlc_pkg::mod10(b_sum_r) == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cls_r <= pass ? b_cls_r : cnlc_pkg::CLS_INVALID;
      out_ok_r  <= pass;
      out_cnt_r <= b_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_ok_r, out_cls_r};

endmodule

FILE: rtl/cnlc_dabble_stage.sv
// ----------------------------------------------------------------------------
// cnlc_dabble_stage
// one registered slice of the binary to bcd shift-and-add-3 conversion
// ----------------------------------------------------------------------------
module cnlc_dabble_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cnlc_pkg::BCD_W-1:0]  in_bcd,
  input  logic [cnlc_pkg::CARD_W-1:0] in_bin,
  output logic                        out_valid_r,
  output logic [cnlc_pkg::BCD_W-1:0]  out_bcd_r,
  output logic [cnlc_pkg::CARD_W-1:0] out_bin_r
);

  logic [cnlc_pkg::BCD_W-1:0]  bcd_nxt;
  logic [cnlc_pkg::CARD_W-1:0] bin_nxt;

  // STEP shift steps, each digit corrected before the shift
  always_comb begin
    bcd_nxt = in_bcd;
    bin_nxt = in_bin;
    for (int s = 0; s < cnlc_pkg::STEP; s++) begin
      for (int k = 0; k < cnlc_pkg::NDIG; k++) begin
        if (bcd_nxt[4*k +: 4] >= 4'd5) begin
          bcd_nxt[4*k +: 4] = bcd_nxt[4*k +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[cnlc_pkg::BCD_W-2:0], bin_nxt[cnlc_pkg::CARD_W-1]};
      bin_nxt = {bin_nxt[cnlc_pkg::CARD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bcd_r <= bcd_nxt;
      out_bin_r <= bin_nxt;
    end
  end

endmodule

FILE: rtl/cnlc_checker.sv
// ----------------------------------------------------------------------------
// cnlc_checker
// port-level checks of the card number classifier results
// ----------------------------------------------------------------------------
module cnlc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cnlc_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [1:0] cls;
  logic       ok;
  logic [4:0] cnt;

  assign cls = out_tdata[1:0];
  assign ok  = out_tdata[2];
  assign cnt = out_tdata[7:3];

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a held result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // any issuer class needs a passing checksum
  a_cls_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cls != cnlc_pkg::CLS_INVALID) |-> ok)
    else $error("class given without luhn pass");

  // class agrees with the digit count
  a_cls_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((cls != cnlc_pkg::CLS_15_3X) || (cnt == 5'd15)) &&
      ((cls != cnlc_pkg::CLS_16_5X) || (cnt == 5'd16)) &&
      ((cls != cnlc_pkg::CLS_LEAD_4) || (cnt == 5'd13) || (cnt == 5'd16)))
    else $error("class inconsistent with digit count");

  // a pass needs at least one digit, and no number has more than seventeen
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt <= 5'(cnlc_pkg::NDIG)) && (!ok || (cnt != 5'd0)))
    else $error("digit count out of range");

endmodule

bind card_number_luhn_classifier cnlc_checker u_cnlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
